### hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, codes and parity helpers for the 32/26 SECDED codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned DataW = 26;
  localparam int unsigned SyndW = 5;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_CLEAN     = 2'd0;
  localparam logic [1:0] STAT_CORRECTED = 2'd1;
  localparam logic [1:0] STAT_DOUBLE    = 2'd2;

  // Syndrome bit k covers every position whose index has bit k set
  localparam logic [WordW-1:0] SYND_MASK [SyndW] = '{
    32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
  };

  typedef struct packed {
    logic             opcode;
    logic [WordW-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic [1:0]       status;
  } rsp_t;

  function automatic logic [SyndW-1:0] syndrome(input logic [WordW-1:0] w);
    logic [SyndW-1:0] s;
    for (int k = 0; k < SyndW; k++) begin
      s[k] = ^(w & SYND_MASK[k]);
    end
    return s;
  endfunction

  // Data bits go to the positions above 0 that are not powers of two
  function automatic logic [WordW-1:0] place_data(input logic [DataW-1:0] d);
    logic [WordW-1:0] cw;
    cw        = '0;
    cw[3]     = d[0];
    cw[7:5]   = d[3:1];
    cw[15:9]  = d[10:4];
    cw[31:17] = d[25:11];
    return cw;
  endfunction

  function automatic logic [DataW-1:0] extract_data(input logic [WordW-1:0] cw);
    return {cw[31:17], cw[15:9], cw[7:5], cw[3]};
  endfunction

endpackage

### hdl/hsc_core.sv
// ----------------------------------------------------------------------------
// hsc_core
// Single-pass encode / decode logic between the input and result registers.
// ----------------------------------------------------------------------------
module hsc_core import hsc_pkg::*; (
  input  cmd_t cmd_i,
  output rsp_t rsp_o
);

  logic [WordW-1:0] enc_base;
  logic [SyndW-1:0] enc_chk;
  logic [WordW-1:0] enc_word;
  logic [SyndW-1:0] dec_synd;
  logic             dec_par;
  logic [WordW-1:0] dec_fixed;

  // Encode: check bits from the placed data, then overall parity over 31..1
  always_comb begin
    enc_base     = place_data(cmd_i.word[DataW-1:0]);
    enc_chk      = syndrome(enc_base);
    enc_word     = enc_base;
    enc_word[1]  = enc_chk[0];
    enc_word[2]  = enc_chk[1];
    enc_word[4]  = enc_chk[2];
    enc_word[8]  = enc_chk[3];
    enc_word[16] = enc_chk[4];
    enc_word[0]  = ^enc_word[WordW-1:1];
  end

  always_comb begin
    dec_synd  = syndrome(cmd_i.word);
    dec_par   = ^cmd_i.word;
    // syndrome zero with odd parity flips bit 0, which holds no data
    dec_fixed = cmd_i.word ^ (WordW'(1) << dec_synd);
  end

  always_comb begin
    rsp_o = '0;
    unique case (cmd_i.opcode)
      OP_ENCODE: begin
        rsp_o.result_word = enc_word;
        rsp_o.status      = STAT_CLEAN;
      end
      OP_DECODE: begin
        priority if (dec_par) begin
          rsp_o.result_word = WordW'(extract_data(dec_fixed));
          rsp_o.status      = STAT_CORRECTED;
        end else if (dec_synd != '0) begin
          rsp_o.result_word = '0;
          rsp_o.status      = STAT_DOUBLE;
        end else begin
          rsp_o.result_word = WordW'(extract_data(cmd_i.word));
          rsp_o.status      = STAT_CLEAN;
        end
      end
      default: rsp_o = '0;
    endcase
  end

endmodule

### hdl/hamming_secded_32_26_codec.sv
// ----------------------------------------------------------------------------
// hamming_secded_32_26_codec
// Extended Hamming SECDED encoder / decoder, one word per cycle.
// ----------------------------------------------------------------------------
//  Channel  | Ports              | Transfer
//  ---------+--------------------+----------------------------------
//  command  | start, busy, cmd_i | start high while busy low
//  result   | done_o, rsp_o      | done_o high, one cycle, no stall
//
//  A command is registered on transfer and its result is registered on the
//  next edge, when done_o rises; the result then transfers to the receiver.
//  The encode/decode logic is one combinational pass, so a new command is
//  taken every cycle and busy stays low.
//  Reset clears the valid flags only; no result is lost to stalls as the
//  receiver always takes it.
// ----------------------------------------------------------------------------
module hamming_secded_32_26_codec import hsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic done_q;
  rsp_t rsp_q;
  rsp_t core_rsp;

  assign busy    = 1'b0;
  assign valid_d = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      cmd_q <= cmd_i;
    end
    if (valid_q) begin
      rsp_q <= core_rsp;
    end
  end

  hsc_core u_core (
    .cmd_i (cmd_q),
    .rsp_o (core_rsp)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A fresh codeword must check clean
  a_enc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && cmd_q.opcode == OP_ENCODE |->
      syndrome(core_rsp.result_word) == '0 && ^core_rsp.result_word == 1'b0)
    else $error("encoded word fails its own check");

  a_dec_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && cmd_q.opcode == OP_DECODE |-> core_rsp.result_word[WordW-1:DataW] == '0)
    else $error("decoded data wider than 26 bits");

  a_double_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == STAT_DOUBLE |-> rsp_o.result_word == '0)
    else $error("double error result not cleared");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2))
    else $error("result without a command two cycles earlier");

endmodule

### test/hamming_secded_32_26_codec_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamming_secded_32_26_codec_test
// Self-checking bench for the 32/26 SECDED codec.
// Directed encodes and decodes cover clean words and the error cases:
// a flipped parity bit, single flips, double flips and heavier damage.
// Random traffic then runs with the sender gapping at different rates.
// Every result is checked against a local SECDED model.
// ----------------------------------------------------------------------------
module hamming_secded_32_26_codec_test;
  import hsc_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 6;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  rsp_t        pending_rsp_q[$];
  int unsigned send_gap_pct;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_op[2];
  int unsigned n_status[3] = '{default: 0};

  hamming_secded_32_26_codec u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .cmd_i (cmd_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // XOR of the indices of all set bits, plus the parity of the whole word
  function automatic logic [4:0] index_xor(input logic [31:0] w, output logic par);
    logic [4:0] s;
    s   = '0;
    par = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) begin
        s   = s ^ 5'(i);
        par = ~par;
      end
    end
    return s;
  endfunction

  function automatic bit is_check_pos(input int i);
    return (i & (i - 1)) == 0;
  endfunction

  function automatic logic [31:0] secded_encode(input logic [31:0] w);
    logic [31:0] cw;
    logic [4:0]  s;
    logic        par;
    int          k;
    cw = '0;
    k  = 0;
    for (int i = 1; i < 32; i++) begin
      if (!is_check_pos(i)) begin
        cw[i] = w[k];
        k++;
      end
    end
    s      = index_xor(cw, par);
    cw[1]  = s[0];
    cw[2]  = s[1];
    cw[4]  = s[2];
    cw[8]  = s[3];
    cw[16] = s[4];
    cw[0]  = ^cw[31:1];
    return cw;
  endfunction

  function automatic logic [31:0] data_bits_of(input logic [31:0] cw);
    logic [31:0] d;
    int          k;
    d = '0;
    k = 0;
    for (int i = 1; i < 32; i++) begin
      if (!is_check_pos(i)) begin
        d[k] = cw[i];
        k++;
      end
    end
    return d;
  endfunction

  function automatic rsp_t predict_codec(input cmd_t c);
    rsp_t        r;
    logic [31:0] w;
    logic [4:0]  s;
    logic        par;
    w = c.word;
    if (c.opcode == OP_ENCODE) begin
      r.result_word = secded_encode(w);
      r.status      = STAT_CLEAN;
    end else begin
      s = index_xor(w, par);
      if (par) begin
        // odd parity: one flip, at bit 0 when the syndrome is zero
        w[s]          = ~w[s];
        r.result_word = data_bits_of(w);
        r.status      = STAT_CORRECTED;
      end else if (s != '0) begin
        r.result_word = '0;
        r.status      = STAT_DOUBLE;
      end else begin
        r.result_word = data_bits_of(w);
        r.status      = STAT_CLEAN;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] flip_bits(input logic [31:0] w, input int unsigned n);
    logic [31:0] m;
    m = '0;
    while ($countones(m) < n) m[$urandom_range(31)] = 1'b1;
    return w ^ m;
  endfunction

  // One command transfer, with random idle cycles ahead of it
  task automatic send(input logic op, input logic [31:0] w);
    cmd_t c;
    c.opcode = op;
    c.word   = w;
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    pending_rsp_q.push_back(predict_codec(c));
    n_op[op]++;
  endtask

  task automatic test_encode();
    send(OP_ENCODE, 32'h0000_0000);
    send(OP_ENCODE, 32'h03FF_FFFF);
    send(OP_ENCODE, 32'hFFFF_FFFF);
    send(OP_ENCODE, 32'hFC00_0000);
    send(OP_ENCODE, 32'h02AA_AAAA);
    send(OP_ENCODE, 32'h0155_5555);
  endtask

  task automatic test_decode_clean();
    send(OP_DECODE, secded_encode(32'h03FF_FFFF));
    send(OP_DECODE, secded_encode(32'h0123_4567));
    send(OP_DECODE, 32'h0000_0000);
  endtask

  task automatic test_single_error();
    logic [31:0] cw;
    cw = secded_encode(32'h02C0_FFEE);
    send(OP_DECODE, cw ^ 32'h0000_0001);
    send(OP_DECODE, cw ^ 32'h0000_0008);
    send(OP_DECODE, cw ^ 32'h0001_0000);
    send(OP_DECODE, cw ^ 32'h8000_0000);
  endtask

  task automatic test_double_error();
    logic [31:0] cw;
    cw = secded_encode(32'h0155_AA33);
    send(OP_DECODE, cw ^ 32'h0010_0020);
    send(OP_DECODE, cw ^ 32'h0000_0201);
  endtask

  task automatic test_multi_error();
    logic [31:0] cw;
    cw = secded_encode(32'h0087_1E5D);
    send(OP_DECODE, cw ^ 32'h0000_1048);
    send(OP_DECODE, 32'hFFFF_FFFF);
  endtask

  // Mostly damaged codewords with random data; some raw noise and encodes
  task automatic test_random(input int unsigned count, input int unsigned gap_pct);
    int unsigned roll;
    send_gap_pct = gap_pct;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        send(OP_ENCODE, $urandom);
      end else if (roll < 25) begin
        send(OP_DECODE, $urandom);
      end else begin
        send(OP_DECODE, flip_bits(secded_encode($urandom),
                                  roll < 45 ? 0 : roll < 75 ? 1 : roll < 92 ? 2 : 3));
      end
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        $error("result with none outstanding: result_word %h status %0d",
               rsp_o.result_word, rsp_o.status);
        errors++;
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (rsp_o.result_word !== exp_rsp.result_word) begin
          $error("result_word: expected %h, got %h", exp_rsp.result_word, rsp_o.result_word);
          errors++;
        end
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_o.status);
          errors++;
        end
        if (exp_rsp.status < 3) n_status[exp_rsp.status]++;
      end
    end
  end

  // Watchdog on cycles with no transfer either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = '0;
    send_gap_pct = 27;
    n_op         = '{default: 0};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_encode();
    test_decode_clean();
    test_single_error();
    test_double_error();
    test_multi_error();
    test_random(460, 27);
    test_random(460, 79);
    test_random(460, 0);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d encodes and %0d decodes.", n_op[OP_ENCODE], n_op[OP_DECODE]);
    $display("Results: %0d clean, %0d corrected, %0d double error.",
             n_status[STAT_CLEAN], n_status[STAT_CORRECTED], n_status[STAT_DOUBLE]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
